FILE: rtl/lea_pkg.sv
// Shared types, constants and round-key table for the LEA-128 round pipeline.
`timescale 1ns / 1ps

package lea_pkg;

   localparam int LEA_WORD_W     = 32;
   localparam int LEA_CNT_W      = 5;
   localparam int LEA_MAX_ROUNDS = 24;
   localparam int LEA_KEY_IDX_W  = LEA_CNT_W + 2;
   // one register stage per round cell
   localparam int LEA_LATENCY    = LEA_MAX_ROUNDS;

   localparam logic [LEA_CNT_W-1:0] LEA_ROUNDS_RESET = LEA_CNT_W'(11);
   localparam logic [LEA_CNT_W-1:0] LEA_ROUNDS_MAX   = LEA_CNT_W'(LEA_MAX_ROUNDS);

   // precomputed round keys, four words per round
   localparam logic [LEA_WORD_W-1:0] LEA_KEY_TABLE [0:LEA_MAX_ROUNDS*4-1] = '{
      32'h003a0fd4, 32'h02497010, 32'h194f7db1, 32'h090d0883,
      32'h11fdcbb1, 32'h9e98e0c8, 32'h18b570cf, 32'h9dc53a79,
      32'hf30f7bb5, 32'h6d6628db, 32'hb74e5dad, 32'ha65e46d0,
      32'h74120631, 32'hdac9bd17, 32'hcd1ecf34, 32'h540f76f1,
      32'h662147db, 32'hc637c47a, 32'h46518932, 32'h23269260,
      32'he4dd5047, 32'hf694285e, 32'he1c2951d, 32'h8ca5242c,
      32'hbaf8e5ca, 32'h3e936cd7, 32'h0fc7e5b1, 32'hf1c8fa8c,
      32'h5522b80c, 32'hee22ca78, 32'h8a6fa8b3, 32'h65637b74,
      32'h8a19279e, 32'h6fb40ffe, 32'h85c5f092, 32'h92cc9f25,
      32'h9dde584c, 32'hcb00c87f, 32'h4780ad66, 32'he61b5dcb,
      32'h4fa10466, 32'hf728e276, 32'hd255411b, 32'h656839ad,
      32'h9250d058, 32'h51bd501f, 32'h1cb40dae, 32'h1abf218d,
      32'h21dd192d, 32'h77c644e2, 32'hcabfaa45, 32'h681c207d,
      32'hde7ac372, 32'h9436afd0, 32'h10331d80, 32'hf326fe98,
      32'hfb3ac3d4, 32'h93df660e, 32'h2f65d8a3, 32'hdf92e761,
      32'h27620087, 32'h265ef76e, 32'h4fb29864, 32'h2656ed1a,
      32'h227b88ec, 32'hd0b3fa6f, 32'hc86a08fd, 32'ha864cba9,
      32'hf1002361, 32'he5e85fc3, 32'h1f0b0408, 32'h488e7ac4,
      32'hc65415d5, 32'h51e176b6, 32'heca88bf9, 32'hedb89ece,
      32'h9b6fb99c, 32'h0548254b, 32'h8de9f7c2, 32'hb6b4d146,
      32'h7257f134, 32'h06051a42, 32'h36bcef01, 32'hb649d524,
      32'ha540fb03, 32'h34b196e6, 32'hf7c80dad, 32'h71bc7dc4,
      32'h8fbee745, 32'hcf744123, 32'h907c0a60, 32'h8215ec35,
      32'h0bf6adba, 32'hdf69029d, 32'h5b72305a, 32'hcb47c19f
   };

   // one item as it moves down the chain
   typedef struct packed {
      logic                  valid;
      logic [LEA_CNT_W-1:0]  count;
      logic [LEA_WORD_W-1:0] w0;
      logic [LEA_WORD_W-1:0] w1;
      logic [LEA_WORD_W-1:0] w2;
      logic [LEA_WORD_W-1:0] w3;
   } lea_stage_type;

   function automatic logic [LEA_WORD_W-1:0] lea_bswap(input logic [LEA_WORD_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

FILE: rtl/lea128_round_encrypt_core.sv
// Top level: LEA-128 reduced-round encryption as a chain of round cells.
// An accepted item reaches rsp_valid through the chain, one register per round cell.
// Throughput: one item per cycle; busy is always low and the chain never stalls.
// Items that need fewer rounds pass through the remaining cells unchanged.
// Reset clears the round count to 11 and drops every item in flight.
// Results are shown for one cycle on rsp_valid; the receiver cannot stall.
`timescale 1ns / 1ps

module lea128_round_encrypt_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  req_in_word0,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  req_in_word1,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  req_in_word2,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  req_in_word3,
   output logic                            rsp_valid,
   output logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word0,
   output logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word1,
   output logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word2,
   output logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word3,
   input  logic                            csr_we,
   input  logic [lea_pkg::LEA_CNT_W-1:0]   csr_wdata
);
   import lea_pkg::*;

   logic [LEA_CNT_W-1:0] rounds_ff;
   logic [LEA_CNT_W-1:0] rounds_in;
   logic [LEA_CNT_W-1:0] rounds_sat;
   lea_stage_type        stage [0:LEA_MAX_ROUNDS];

   // hold the round count register, or load it from csr_wdata on a write
   always_comb begin
      rounds_in = rounds_ff;
      if (csr_we) begin
         rounds_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_ff <= LEA_ROUNDS_RESET;
      end else begin
         rounds_ff <= rounds_in;
      end
   end

   // cap the count at the rounds the key table holds
   assign rounds_sat = (rounds_ff > LEA_ROUNDS_MAX) ? LEA_ROUNDS_MAX : rounds_ff;

   assign busy = 1'b0;

   // byte-swap the words on entry
   always_comb begin
      stage[0].valid = start && !busy;
      stage[0].count = rounds_sat;
      stage[0].w0    = lea_bswap(req_in_word0);
      stage[0].w1    = lea_bswap(req_in_word1);
      stage[0].w2    = lea_bswap(req_in_word2);
      stage[0].w3    = lea_bswap(req_in_word3);
   end

   // chain of round cells
   for (genvar g = 0; g < LEA_MAX_ROUNDS; g++) begin : g_cell
      lea_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .round_idx (LEA_CNT_W'(g)),
         .stage_in  (stage[g]),
         .stage_out (stage[g+1])
      );
   end

   // byte-swap the words on exit
   assign rsp_valid     = stage[LEA_MAX_ROUNDS].valid;
   assign rsp_out_word0 = lea_bswap(stage[LEA_MAX_ROUNDS].w0);
   assign rsp_out_word1 = lea_bswap(stage[LEA_MAX_ROUNDS].w1);
   assign rsp_out_word2 = lea_bswap(stage[LEA_MAX_ROUNDS].w2);
   assign rsp_out_word3 = lea_bswap(stage[LEA_MAX_ROUNDS].w3);

endmodule

FILE: rtl/lea_round_cell.sv
// One LEA round cell: applies its round if the item still needs it, then registers.
`timescale 1ns / 1ps

module lea_round_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lea_pkg::LEA_CNT_W-1:0]   round_idx,
   input  lea_pkg::lea_stage_type          stage_in,
   output lea_pkg::lea_stage_type          stage_out
);
   import lea_pkg::*;

   logic [LEA_KEY_IDX_W-1:0] key_base;
   logic [LEA_WORD_W-1:0]    t0, t1, t2, t3;
   logic [LEA_WORD_W-1:0]    sum0, sum1, sum2;
   logic                     apply;
   lea_stage_type            stage_in_val;
   lea_stage_type            stage_ff;
   logic                     valid_ff;

   // fetch this round's key words
   assign key_base = {round_idx, 2'b00};
   assign t0 = LEA_KEY_TABLE[key_base | LEA_KEY_IDX_W'(0)];
   assign t1 = LEA_KEY_TABLE[key_base | LEA_KEY_IDX_W'(1)];
   assign t2 = LEA_KEY_TABLE[key_base | LEA_KEY_IDX_W'(2)];
   assign t3 = LEA_KEY_TABLE[key_base | LEA_KEY_IDX_W'(3)];

   // round function, modulo 2^32 adds
   assign sum0 = (stage_in.w0 ^ t0) + (stage_in.w1 ^ t1);
   assign sum1 = (stage_in.w1 ^ t2) + (stage_in.w2 ^ t1);
   assign sum2 = (stage_in.w2 ^ t3) + (stage_in.w3 ^ t1);

   assign apply = (round_idx < stage_in.count);

   // pick round result or pass the item through unchanged
   always_comb begin
      stage_in_val = stage_in;
      if (apply) begin
         stage_in_val.w0 = {sum0[22:0], sum0[31:23]};
         stage_in_val.w1 = {sum1[4:0], sum1[31:5]};
         stage_in_val.w2 = {sum2[2:0], sum2[31:3]};
         stage_in_val.w3 = stage_in.w0;
      end
   end

   // advance payload every cycle
   always_ff @(posedge clock) begin
      stage_ff <= stage_in_val;
   end

   // clear the item marker on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_comb begin
      stage_out       = stage_ff;
      stage_out.valid = valid_ff;
   end

endmodule

FILE: rtl/lea_core_checker.sv
// Port-level checker for the LEA-128 round core, bound to the top level.
`timescale 1ns / 1ps

module lea_core_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            rsp_valid,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word0
);
   import lea_pkg::*;

   // the chain never holds items off
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // every accepted item comes out after the fixed latency
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LEA_LATENCY rsp_valid)
      else $error("accepted item did not appear at the output");

   // no result without an accepted item the fixed latency earlier
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LEA_LATENCY))
      else $error("result without a matching item");

   // nothing comes out in the first cycle after reset
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   // a shown result carries known data
   a_known_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_out_word0))
      else $error("unknown bits on a result");

endmodule

bind lea128_round_encrypt_core lea_core_checker u_lea_core_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_out_word0 (rsp_out_word0)
);

FILE: verif/lea128_round_encrypt_checker.sv
// Scoreboard for the LEA-128 reduced-round core: predicts each ciphertext and compares results.
`timescale 1ns / 1ps

module lea128_round_encrypt_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  req_in_word0,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  req_in_word1,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  req_in_word2,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  req_in_word3,
   input  logic                            rsp_valid,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word0,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word1,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word2,
   input  logic [lea_pkg::LEA_WORD_W-1:0]  rsp_out_word3,
   input  logic                            csr_we,
   input  logic [lea_pkg::LEA_CNT_W-1:0]   csr_wdata,
   output int                              fail_count,
   output int                              pending_blocks
);

   localparam int W = lea_pkg::LEA_WORD_W;

   typedef logic [W-1:0] word_t;
   typedef word_t block_t [4];

   logic [lea_pkg::LEA_CNT_W-1:0] rounds_in_use;
   logic [4*W-1:0]                expected_ct_q [$];

   function automatic word_t swap_word_bytes(input word_t v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // Encrypt one block with the given round count, words packed w0 in the top slot
   function automatic logic [4*W-1:0] lea_encrypt_block(
      input logic [lea_pkg::LEA_CNT_W-1:0] rounds,
      input logic [4*W-1:0]                plain
   );
      word_t x0, x1, x2, x3, s0, s1, s2, t0, t1, t2, t3;
      int    nr;
      x0 = swap_word_bytes(plain[4*W-1:3*W]);
      x1 = swap_word_bytes(plain[3*W-1:2*W]);
      x2 = swap_word_bytes(plain[2*W-1:W]);
      x3 = swap_word_bytes(plain[W-1:0]);
      // saturate the count at the depth of the key table
      nr = (rounds > lea_pkg::LEA_ROUNDS_MAX) ? lea_pkg::LEA_MAX_ROUNDS : int'(rounds);
      for (int r = 0; r < nr; r++) begin
         t0 = lea_pkg::LEA_KEY_TABLE[4*r];
         t1 = lea_pkg::LEA_KEY_TABLE[4*r+1];
         t2 = lea_pkg::LEA_KEY_TABLE[4*r+2];
         t3 = lea_pkg::LEA_KEY_TABLE[4*r+3];
         s0 = (x0 ^ t0) + (x1 ^ t1);
         s1 = (x1 ^ t2) + (x2 ^ t1);
         s2 = (x2 ^ t3) + (x3 ^ t1);
         x3 = x0;
         x0 = {s0[22:0], s0[31:23]};
         x1 = {s1[4:0], s1[31:5]};
         x2 = {s2[2:0], s2[31:3]};
      end
      return {swap_word_bytes(x0), swap_word_bytes(x1),
              swap_word_bytes(x2), swap_word_bytes(x3)};
   endfunction

   // Track the register, queue predictions on accept, compare on each result strobe
   always @(posedge clock) begin
      logic [4*W-1:0] want;
      block_t         got_w, want_w;
      int             bad;
      bad = 0;
      if (reset) begin
         rounds_in_use <= lea_pkg::LEA_ROUNDS_RESET;
         expected_ct_q.delete();
         pending_blocks <= 0;
      end else begin
         if (rsp_valid) begin
            got_w = '{rsp_out_word0, rsp_out_word1, rsp_out_word2, rsp_out_word3};
            if (expected_ct_q.size() == 0) begin
               bad = 1;
               if (fail_count < 10)
                  $display("%0t: result with no item pending: %h %h %h %h",
                           $realtime, got_w[0], got_w[1], got_w[2], got_w[3]);
            end else begin
               want = expected_ct_q.pop_front();
               want_w = '{want[4*W-1:3*W], want[3*W-1:2*W], want[2*W-1:W], want[W-1:0]};
               for (int i = 0; i < 4; i++) begin
                  if (got_w[i] !== want_w[i]) begin
                     if (fail_count + bad < 10)
                        $display("%0t: out_word%0d mismatch: expected %h actual %h",
                                 $realtime, i, want_w[i], got_w[i]);
                     bad = bad + 1;
                  end
               end
            end
         end
         if (start && !busy)
            expected_ct_q.push_back(lea_encrypt_block(rounds_in_use,
               {req_in_word0, req_in_word1, req_in_word2, req_in_word3}));
         if (csr_we)
            rounds_in_use <= csr_wdata;
         pending_blocks <= expected_ct_q.size();
      end
      if (bad != 0)
         fail_count <= fail_count + bad;
   end

endmodule

FILE: verif/lea128_round_encrypt_core_tb.sv
// Testbench top for the LEA-128 reduced-round core: stimulus, round-count sweeps and verdict.
`timescale 1ns / 1ps

module lea128_round_encrypt_core_tb;

   localparam int W         = lea_pkg::LEA_WORD_W;
   localparam int PHASES    = 8;
   localparam int PHASE_LEN = 50;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [W-1:0]                  req_in_word0, req_in_word1, req_in_word2, req_in_word3;
   logic                          rsp_valid;
   logic [W-1:0]                  rsp_out_word0, rsp_out_word1, rsp_out_word2, rsp_out_word3;
   logic                          csr_we;
   logic [lea_pkg::LEA_CNT_W-1:0] csr_wdata;

   int fail_count;
   int pending_blocks;
   int gap_pct;

   logic [lea_pkg::LEA_CNT_W-1:0] phase_rounds [PHASES];

   lea128_round_encrypt_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_in_word0  (req_in_word0),
      .req_in_word1  (req_in_word1),
      .req_in_word2  (req_in_word2),
      .req_in_word3  (req_in_word3),
      .rsp_valid     (rsp_valid),
      .rsp_out_word0 (rsp_out_word0),
      .rsp_out_word1 (rsp_out_word1),
      .rsp_out_word2 (rsp_out_word2),
      .rsp_out_word3 (rsp_out_word3),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata)
   );

   lea128_round_encrypt_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_in_word0   (req_in_word0),
      .req_in_word1   (req_in_word1),
      .req_in_word2   (req_in_word2),
      .req_in_word3   (req_in_word3),
      .rsp_valid      (rsp_valid),
      .rsp_out_word0  (rsp_out_word0),
      .rsp_out_word1  (rsp_out_word1),
      .rsp_out_word2  (rsp_out_word2),
      .rsp_out_word3  (rsp_out_word3),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_blocks (pending_blocks)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bound the run well past the slowest legal finish
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Bias toward carry-heavy corners now and then
   function automatic logic [W-1:0] pick_word();
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return '1;
         2:       return W'(1) << $urandom_range(W-1, 0);
         default: return $urandom();
      endcase
   endfunction

   // Idle the sender cycle by cycle at random, then present one item and hold until accepted
   task automatic send_block(input logic [W-1:0] a, b, c, d);
      while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_in_word0 <= a;
      req_in_word1 <= b;
      req_in_word2 <= c;
      req_in_word3 <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted item has come back
   task automatic drain_blocks();
      start <= 1'b0;
      @(posedge clock);
      while (pending_blocks != 0) @(posedge clock);
   endtask

   // Change the round count only with the core empty
   task automatic write_rounds(input logic [lea_pkg::LEA_CNT_W-1:0] v);
      drain_blocks();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      reset        <= 1'b1;
      start        <= 1'b0;
      req_in_word0 <= '0;
      req_in_word1 <= '0;
      req_in_word2 <= '0;
      req_in_word3 <= '0;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      gap_pct       = 0;
      phase_rounds  = '{5'd11, 5'd24, 5'd1, 5'd31, 5'd0, 5'd23,
                        5'($urandom_range(31, 0)), 5'($urandom_range(24, 2))};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corners at the reset round count
      send_block(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
      send_block(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_block(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
      send_block(32'h80000000, 32'h00000001, 32'h80000000, 32'h00000001);
      send_block(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
      send_block(32'h000000ff, 32'h0000ff00, 32'h00ff0000, 32'hff000000);
      send_block(32'hffffffff, 32'h00000000, 32'h00000000, 32'h00000000);
      send_block(32'h00000000, 32'h00000000, 32'h00000000, 32'hffffffff);

      // zero rounds: byte swaps cancel, output mirrors input
      write_rounds(5'd0);
      send_block(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
      send_block(32'hffffffff, 32'h00000000, 32'h80000001, 32'h7ffffffe);

      // counts above the table depth saturate at the full round count
      write_rounds(5'd31);
      send_block(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
      send_block(32'hdeadbeef, 32'hcafef00d, 32'h12345678, 32'h9abcdef0);
      write_rounds(5'd25);
      send_block(32'hdeadbeef, 32'hcafef00d, 32'h12345678, 32'h9abcdef0);
      write_rounds(lea_pkg::LEA_ROUNDS_MAX);
      send_block(32'hdeadbeef, 32'hcafef00d, 32'h12345678, 32'h9abcdef0);
      send_block(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);

      // single round
      write_rounds(5'd1);
      send_block(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
      send_block(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_block(32'h00000001, 32'h00000002, 32'h00000004, 32'h00000008);

      // random phases: light sender gaps, then heavy, then back-to-back
      for (int ph = 0; ph < PHASES; ph++) begin
         write_rounds(phase_rounds[ph]);
         gap_pct = (ph < 3) ? 11 : (ph < 6) ? 45 : 0;
         for (int n = 0; n < PHASE_LEN; n++)
            send_block(pick_word(), pick_word(), pick_word(), pick_word());
      end

      drain_blocks();
      repeat (lea_pkg::LEA_LATENCY + 4) @(posedge clock);
      if (fail_count == 0 && pending_blocks == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
